// ----- hw/rtl/hpsa_pkg.sv -----
// Package for the hall period, speed and angle estimator.
// Holds the field widths, counter limits and the state encoding.
// No dependencies; used by hpsa_div and the top level.
package hpsa_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int ANGLE_BITS  = 16;
  localparam int SCALE_W     = 32;
  localparam int SPEED_W     = 32;
  localparam int ANGLE_W     = ANGLE_BITS + 1;

  // The divider handles both the speed and the angle division.
  localparam int DIV_W   = (COUNT_WIDTH > SCALE_W) ? COUNT_WIDTH : SCALE_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);

  localparam logic [SCALE_W-1:0]     SCALE_RESET = SCALE_W'(100530965);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [ANGLE_BITS-1:0]  HALF_TURN   = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  localparam logic [STEP_W-1:0] SPEED_STEPS = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] ANGLE_STEPS = STEP_W'(ANGLE_BITS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_SPEED = 5'b00100,
    ST_ANGLE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Command to the serial divider.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_W-1:0]  num_init;
    logic [DIV_W-1:0]  den;
  } div_cmd_t;

endpackage

// ----- hw/rtl/hpsa_div.sv -----
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Shared by the speed and the angle computations of the estimator.
// Depends on hpsa_pkg.
module hpsa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  hpsa_pkg::div_cmd_t         cmd,
  output logic                       done,
  output logic [hpsa_pkg::DIV_W-1:0] quot
);

  logic [hpsa_pkg::DIV_W-1:0]  rem;
  logic [hpsa_pkg::DIV_W-1:0]  num;
  logic [hpsa_pkg::DIV_W-1:0]  den;
  logic [hpsa_pkg::STEP_W-1:0] cnt;
  logic                        busy;

  logic [hpsa_pkg::DIV_W:0] trial;
  logic [hpsa_pkg::DIV_W:0] diff;
  logic                     qbit;

  // The remainder is always below the divisor, so the shifted trial fits.
  assign trial = {rem, num[hpsa_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == hpsa_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= cmd.rem_init;
      num  <= cmd.num_init;
      den  <= cmd.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[hpsa_pkg::DIV_W-1:0] : trial[hpsa_pkg::DIV_W-1:0];
      num  <= {num[hpsa_pkg::DIV_W-2:0], 1'b0};
      quot <= {quot[hpsa_pkg::DIV_W-2:0], qbit};
    end
  end

endmodule

// ----- hw/rtl/hall_period_speed_angle_estimator_unit.sv -----
// Top level of the hall period, speed and angle estimator.
// Depends on hpsa_pkg and hpsa_div.
//
// Usage:
// Each input beat on in_valid/in_stall is one tick of the time base; edge_req
// marks the tick in which the once-per-revolution hall edge arrived. Every
// input beat yields exactly one output beat on out_valid/out_stall carrying
// speed (unsigned Q28.4 rad/s), angle (signed, half the range is pi) and
// period_known.
// A tick with an edge that closes a revolution runs a 32-step bit-serial
// division for the speed. Other ticks with a known period that has not
// yet elapsed run a 16-step division for the angle. Ticks before a period
// is known, and overdue ticks, skip the division.
// One tick is handled at a time; in_stall is high while a tick is in work.
// The result register lets the next tick be taken while a result waits; if
// the receiver still stalls when the next result is ready, the block holds
// it and keeps in_stall high. cfg_wr_en writes speed_scale; write it only
// while idle. Synchronous reset clears the counters, the period and the
// speed, and sets speed_scale to its default.
module hall_period_speed_angle_estimator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [hpsa_pkg::SCALE_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           edge_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hpsa_pkg::SPEED_W-1:0]   speed,
  output logic signed [hpsa_pkg::ANGLE_W-1:0] angle,
  output logic                           period_known
);

  hpsa_pkg::state_t state, state_next;

  logic [hpsa_pkg::SCALE_W-1:0]     speed_scale;
  logic [hpsa_pkg::COUNT_WIDTH-1:0] elapsed;
  logic [hpsa_pkg::COUNT_WIDTH-1:0] period;
  logic                             seen_edge;
  logic [hpsa_pkg::SPEED_W-1:0]     speed_value;
  logic                             spd_pend;
  logic [hpsa_pkg::ANGLE_W-1:0]     angle_res;

  logic [hpsa_pkg::COUNT_WIDTH-1:0] el_inc;
  logic                             in_beat;
  logic                             known;
  logic                             out_free;

  hpsa_pkg::div_cmd_t          cmd;
  logic                        div_done;
  logic [hpsa_pkg::DIV_W-1:0]  quot;
  logic [hpsa_pkg::ANGLE_BITS-1:0] p;

  hpsa_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (div_done),
    .quot (quot)
  );

  assign in_stall = (state != hpsa_pkg::ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign known    = (period != '0);
  assign out_free = !out_valid || !out_stall;
  assign el_inc   = (elapsed == hpsa_pkg::COUNT_MAX) ? elapsed : elapsed + 1'b1;
  assign p        = quot[hpsa_pkg::ANGLE_BITS-1:0];

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.steps    = hpsa_pkg::ANGLE_STEPS;
    cmd.rem_init = hpsa_pkg::DIV_W'(elapsed);
    cmd.num_init = '0;
    cmd.den      = hpsa_pkg::DIV_W'(period);
    unique case (state)
      hpsa_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = hpsa_pkg::ST_EVAL;
        end
      end
      hpsa_pkg::ST_EVAL: begin
        if (spd_pend) begin
          cmd.start    = 1'b1;
          cmd.steps    = hpsa_pkg::SPEED_STEPS;
          cmd.rem_init = '0;
          cmd.num_init = hpsa_pkg::DIV_W'(speed_scale);
          state_next   = hpsa_pkg::ST_SPEED;
        end else if (known && (elapsed < period)) begin
          cmd.start  = 1'b1;
          state_next = hpsa_pkg::ST_ANGLE;
        end else begin
          state_next = hpsa_pkg::ST_DONE;
        end
      end
      hpsa_pkg::ST_SPEED: begin
        if (div_done) begin
          state_next = hpsa_pkg::ST_DONE;
        end
      end
      hpsa_pkg::ST_ANGLE: begin
        if (div_done) begin
          state_next = hpsa_pkg::ST_DONE;
        end
      end
      hpsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = hpsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hpsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hpsa_pkg::ST_IDLE;
      speed_scale <= hpsa_pkg::SCALE_RESET;
      elapsed     <= '0;
      period      <= '0;
      seen_edge   <= 1'b0;
      speed_value <= '0;
      spd_pend    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        speed_scale <= cfg_wr_data;
      end
      if (in_beat) begin
        spd_pend <= edge_req && seen_edge;
        if (edge_req) begin
          if (seen_edge) begin
            period <= el_inc;
          end
          seen_edge <= 1'b1;
          elapsed   <= '0;
        end else begin
          elapsed <= el_inc;
        end
      end
      if (state == hpsa_pkg::ST_SPEED && div_done) begin
        speed_value <= quot[hpsa_pkg::SPEED_W-1:0];
      end
      if (state == hpsa_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Angle result. After an edge the elapsed count is zero, so the angle is
  // zero; an overdue edge clamps to a full turn, which also wraps to zero.
  always_ff @(posedge clk) begin
    if (state == hpsa_pkg::ST_EVAL) begin
      angle_res <= '0;
    end else if (state == hpsa_pkg::ST_ANGLE && div_done) begin
      angle_res <= (p > hpsa_pkg::HALF_TURN) ? {1'b1, p} : {1'b0, p};
    end
  end

  always_ff @(posedge clk) begin
    if (state == hpsa_pkg::ST_DONE && out_free) begin
      speed        <= speed_value;
      angle        <= angle_res;
      period_known <= known;
    end
  end

endmodule
